FILE: src/max_sum_bounded_run_select_top_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for max_sum_bounded_run_select_top
// Concurrent check shorthands clocked on clock and held off during reset.
// ----------------------------------------------------------------------------
`ifndef MAX_SUM_BOUNDED_RUN_SELECT_TOP_DEFINES_SVH
`define MAX_SUM_BOUNDED_RUN_SELECT_TOP_DEFINES_SVH

// same-cycle implication
`define MBRS_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define MBRS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: src/mbrs_pkg.sv
// ----------------------------------------------------------------------------
// mbrs_pkg
// Shared types, limits and saturating arithmetic for the bounded-run selector.
// ----------------------------------------------------------------------------
package mbrs_pkg;

   localparam int VALUE_W   = 32;
   localparam int SCORE_W   = 64;
   localparam int POS_W     = 32;
   localparam int RUN_W     = 11;
   localparam int BEST_W    = 63;
   localparam int QUEUE_DEPTH = 2;

   localparam logic signed [SCORE_W-1:0] SCORE_MIN = {1'b1, {(SCORE_W-1){1'b0}}};
   localparam logic signed [SCORE_W-1:0] SCORE_MAX = {1'b0, {(SCORE_W-1){1'b1}}};

   typedef struct packed {
      logic signed [SCORE_W-1:0] value;
      logic                      last;
   } item_type;

   typedef struct packed {
      logic [BEST_W-1:0] best_sum;
      logic              final_res;
   } result_type;

   typedef struct packed {
      logic overrun;
      logic cleared;
   } eng_stat_type;

   function automatic logic signed [SCORE_W-1:0] sat_add(
      input logic signed [SCORE_W-1:0] a,
      input logic signed [SCORE_W-1:0] b
   );
      logic signed [SCORE_W-1:0] s;
      s = a + b;
      if ((a[SCORE_W-1] == b[SCORE_W-1]) && (s[SCORE_W-1] != a[SCORE_W-1])) begin
         sat_add = a[SCORE_W-1] ? SCORE_MIN : SCORE_MAX;
      end else begin
         sat_add = s;
      end
   endfunction

   function automatic logic signed [SCORE_W-1:0] sat_sub(
      input logic signed [SCORE_W-1:0] a,
      input logic signed [SCORE_W-1:0] b
   );
      logic signed [SCORE_W-1:0] d;
      d = a - b;
      if ((a[SCORE_W-1] != b[SCORE_W-1]) && (d[SCORE_W-1] != a[SCORE_W-1])) begin
         sat_sub = a[SCORE_W-1] ? SCORE_MIN : SCORE_MAX;
      end else begin
         sat_sub = d;
      end
   endfunction

endpackage

FILE: src/mbrs_fifo.sv
// ----------------------------------------------------------------------------
// mbrs_fifo
// Small register queue with push/full and pop/empty handshakes.
// ----------------------------------------------------------------------------
module mbrs_fifo #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] data_in,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] data_out,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic             do_push, do_pop;

   assign full     = (fill_ff == FULL_CNT);
   assign empty    = (fill_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign data_out = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= data_in;
      end
   end

endmodule

FILE: src/mbrs_front.sv
// ----------------------------------------------------------------------------
// mbrs_front
// Intake stage: takes request transfers, widens the value to score width and
// hands the item to the work queue.
// ----------------------------------------------------------------------------
module mbrs_front
   import mbrs_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   output logic                      full,
   input  logic signed [VALUE_W-1:0] req_value,
   input  logic                      req_last,
   output logic                      item_valid,
   output item_type                  item,
   input  logic                      queue_full
);

   logic     valid_ff, valid_in;
   item_type item_ff;
   logic     take, drain;

   assign full       = valid_ff && queue_full;
   assign take       = push && !full;
   assign drain      = valid_ff && !queue_full;
   assign item_valid = valid_ff;
   assign item       = item_ff;

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (drain) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff.value <= SCORE_W'(req_value);
         item_ff.last  <= req_last;
      end
   end

endmodule

FILE: src/mbrs_engine.sv
// ----------------------------------------------------------------------------
// mbrs_engine
// Back end: runs the skip/take recurrence for one item at a time against a
// monotonic deque of (skip score - prefix) held in a RAM.
// ----------------------------------------------------------------------------
module mbrs_engine
   import mbrs_pkg::*;
#(
   parameter int MAX_WINDOW = 1024
) (
   input  logic             clock,
   input  logic             reset,
   input  logic [RUN_W-1:0] max_run,
   input  logic             item_valid,
   input  item_type         item,
   output logic             item_pop,
   output logic             res_push,
   output result_type       res,
   input  logic             res_full,
   output eng_stat_type     stat
);

   localparam int IDX_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
   localparam int CNT_W = $clog2(MAX_WINDOW + 1);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_WINDOW - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(MAX_WINDOW);
   localparam logic [CNT_W:0]   WRAP_SUM = (CNT_W+1)'(MAX_WINDOW);

   typedef enum logic [4:0] {
      ST_IDLE      = 5'b00001,
      ST_DROP_NOW  = 5'b00010,
      ST_DROP_NEXT = 5'b00100,
      ST_TRIM      = 5'b01000,
      ST_PUSH      = 5'b10000
   } eng_state_type;

   typedef struct packed {
      logic signed [SCORE_W-1:0] score;
      logic [POS_W-1:0]          pos;
   } entry_type;

   function automatic logic [IDX_W-1:0] wrap_idx(input logic [CNT_W:0] sum);
      if (sum >= WRAP_SUM) begin
         wrap_idx = IDX_W'(sum - WRAP_SUM);
      end else begin
         wrap_idx = IDX_W'(sum);
      end
   endfunction

   eng_state_type state_ff, state_in;

   logic signed [SCORE_W-1:0] prefix_ff, prefix_in;
   logic signed [SCORE_W-1:0] skip_ff, skip_in;
   logic signed [SCORE_W-1:0] take_ff, take_in;
   logic                      take_valid_ff, take_valid_in;
   logic [POS_W-1:0]          pos_count_ff, pos_count_in;
   logic [IDX_W-1:0]          head_ff, head_in;
   logic [CNT_W-1:0]          count_ff, count_in;
   logic                      seed_ff, seed_in;

   logic signed [SCORE_W-1:0] new_skip_ff, new_skip_in;
   logic signed [SCORE_W-1:0] cand_ff, cand_in;
   logic [POS_W-1:0]          pos_ff, pos_in;
   logic                      last_ff, last_in;

   logic signed [SCORE_W-1:0] score_mem [MAX_WINDOW];
   logic [POS_W-1:0]          pos_mem [MAX_WINDOW];
   entry_type                 head_rd_ff, tail_rd_ff;
   logic [IDX_W-1:0]          rd_head_addr, rd_tail_addr;
   logic                      wr_en;
   logic [IDX_W-1:0]          wr_slot;

   logic [RUN_W-1:0]          span;
   logic [IDX_W-1:0]          head_step, tail_idx;
   entry_type                 head_ent, tail_ent;
   logic [POS_W-1:0]          age_now, age_next;
   logic                      deque_live;
   logic signed [SCORE_W-1:0] best;

   assign span = ({{(POS_W-RUN_W){1'b0}}, max_run} > POS_W'(MAX_WINDOW)) ?
                 RUN_W'(MAX_WINDOW) : max_run;

   assign head_step  = (head_ff == LAST_IDX) ? '0 : head_ff + 1'b1;
   assign tail_idx   = wrap_idx((CNT_W+1)'(head_ff) + (CNT_W+1)'(count_ff) - 1'b1);
   assign wr_slot    = wrap_idx((CNT_W+1)'(head_ff) + (CNT_W+1)'(count_ff));
   assign deque_live = (count_ff != '0);

   assign head_ent = (seed_ff && (head_ff == '0)) ? '0 : head_rd_ff;
   assign tail_ent = (seed_ff && (tail_idx == '0)) ? '0 : tail_rd_ff;
   assign age_now  = pos_ff - head_ent.pos;
   assign age_next = (pos_ff + 1'b1) - head_ent.pos;

   assign best = (take_valid_ff && (take_ff > skip_ff)) ? take_ff : skip_ff;

   assign res.best_sum  = best[SCORE_W-1] ? '0 : best[BEST_W-1:0];
   assign res.final_res = last_ff;

   assign stat.overrun = (count_ff > FULL_CNT);
   assign stat.cleared = (count_ff == CNT_W'(1)) && (head_ff == '0) && seed_ff &&
                         (pos_count_ff == '0) && !take_valid_ff;

   always_comb begin
      state_in      = state_ff;
      prefix_in     = prefix_ff;
      skip_in       = skip_ff;
      take_in       = take_ff;
      take_valid_in = take_valid_ff;
      pos_count_in  = pos_count_ff;
      head_in       = head_ff;
      count_in      = count_ff;
      seed_in       = seed_ff;
      new_skip_in   = new_skip_ff;
      cand_in       = cand_ff;
      pos_in        = pos_ff;
      last_in       = last_ff;
      item_pop      = 1'b0;
      res_push      = 1'b0;
      wr_en         = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (item_valid) begin
               item_pop    = 1'b1;
               prefix_in   = sat_add(prefix_ff, item.value);
               new_skip_in = (take_valid_ff && (take_ff > skip_ff)) ? take_ff : skip_ff;
               pos_in      = pos_count_ff + 1'b1;
               last_in     = item.last;
               state_in    = ST_DROP_NOW;
            end
         end
         ST_DROP_NOW: begin
            if (deque_live && (age_now > POS_W'(span))) begin
               head_in  = head_step;
               count_in = count_ff - 1'b1;
            end else begin
               if (deque_live) begin
                  take_in       = sat_add(head_ent.score, prefix_ff);
                  take_valid_in = 1'b1;
               end else begin
                  take_in       = SCORE_MIN;
                  take_valid_in = 1'b0;
               end
               skip_in  = new_skip_ff;
               state_in = ST_DROP_NEXT;
            end
         end
         ST_DROP_NEXT: begin
            if (deque_live && (age_next > POS_W'(span))) begin
               head_in  = head_step;
               count_in = count_ff - 1'b1;
            end else begin
               cand_in  = sat_sub(skip_ff, prefix_ff);
               state_in = ST_TRIM;
            end
         end
         ST_TRIM: begin
            if (deque_live && (tail_ent.score <= cand_ff)) begin
               count_in = count_ff - 1'b1;
            end else begin
               state_in = ST_PUSH;
            end
         end
         ST_PUSH: begin
            if (!res_full) begin
               res_push     = 1'b1;
               pos_count_in = pos_ff;
               if (count_ff != FULL_CNT) begin
                  wr_en    = 1'b1;
                  count_in = count_ff + 1'b1;
                  if (wr_slot == '0) begin
                     seed_in = 1'b0;
                  end
               end
               if (last_ff) begin
                  prefix_in     = '0;
                  skip_in       = '0;
                  take_in       = SCORE_MIN;
                  take_valid_in = 1'b0;
                  pos_count_in  = '0;
                  head_in       = '0;
                  count_in      = CNT_W'(1);
                  seed_in       = 1'b1;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rd_head_addr = head_in;
      if (count_in == '0) begin
         rd_tail_addr = head_in;
      end else begin
         rd_tail_addr = wrap_idx((CNT_W+1)'(head_in) + (CNT_W+1)'(count_in) - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         prefix_ff     <= '0;
         skip_ff       <= '0;
         take_ff       <= SCORE_MIN;
         take_valid_ff <= 1'b0;
         pos_count_ff  <= '0;
         head_ff       <= '0;
         count_ff      <= CNT_W'(1);
         seed_ff       <= 1'b1;
      end else begin
         state_ff      <= state_in;
         prefix_ff     <= prefix_in;
         skip_ff       <= skip_in;
         take_ff       <= take_in;
         take_valid_ff <= take_valid_in;
         pos_count_ff  <= pos_count_in;
         head_ff       <= head_in;
         count_ff      <= count_in;
         seed_ff       <= seed_in;
      end
   end

   always_ff @(posedge clock) begin
      new_skip_ff <= new_skip_in;
      cand_ff     <= cand_in;
      pos_ff      <= pos_in;
      last_ff     <= last_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         score_mem[wr_slot] <= cand_ff;
         pos_mem[wr_slot]   <= pos_ff;
      end
      head_rd_ff.score <= score_mem[rd_head_addr];
      head_rd_ff.pos   <= pos_mem[rd_head_addr];
      tail_rd_ff.score <= score_mem[rd_tail_addr];
      tail_rd_ff.pos   <= pos_mem[rd_tail_addr];
   end

endmodule

FILE: src/max_sum_bounded_run_select_top.sv
// ----------------------------------------------------------------------------
// max_sum_bounded_run_select_top
// Streams signed 32-bit values and reports, after each one, the greatest sum
// of a subset of the values so far in which no run of picked neighbours is
// longer than csr max_run (saturated to MAX_WINDOW; zero forbids picking).
// Every accepted value yields exactly one result; a value with last set
// closes the sequence, its result carries final_res, and the running state
// returns to its reset value while max_run is kept. Sums saturate at the
// signed 64-bit limits and the reported best is never below zero. An item
// walks the states idle, drop-now, drop-next, trim and push, staying in a
// drop state per front retirement, in trim per back retirement and in push
// while the result queue is full; each deque entry is retired at most once.
// The registered deque RAM reads limit the sequencer to one retirement a
// cycle. Two-entry queues on both sides let the intake and result ports
// keep moving while the sequencer works. No clearing pass runs after reset.
// ----------------------------------------------------------------------------
`include "max_sum_bounded_run_select_top_defines.svh"

module max_sum_bounded_run_select_top
   import mbrs_pkg::*;
#(
   parameter int MAX_WINDOW = 1024
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   output logic                      full,
   input  logic signed [VALUE_W-1:0] req_value,
   input  logic                      req_last,
   output logic                      empty,
   input  logic                      pop,
   output logic [BEST_W-1:0]         rsp_best_sum,
   output logic                      rsp_final_res,
   input  logic                      csr_write_en,
   input  logic [RUN_W-1:0]          csr_write_data
);

   localparam int ITEM_W = $bits(item_type);
   localparam int RES_W  = $bits(result_type);

   logic [RUN_W-1:0] max_run_ff;

   logic             front_valid;
   item_type         front_item;
   logic             work_full;
   logic             work_empty;
   logic [ITEM_W-1:0] work_data;
   item_type         work_item;
   logic             work_pop;

   logic             res_push;
   result_type       res_item;
   logic             res_full;
   logic [RES_W-1:0] rsp_data;
   result_type       rsp_item;
   eng_stat_type     eng_stat;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_run_ff <= RUN_W'(1);
      end else if (csr_write_en) begin
         max_run_ff <= csr_write_data;
      end
   end

   mbrs_front u_front (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .full       (full),
      .req_value  (req_value),
      .req_last   (req_last),
      .item_valid (front_valid),
      .item       (front_item),
      .queue_full (work_full)
   );

   mbrs_fifo #(
      .WIDTH (ITEM_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_work_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (front_valid),
      .data_in  (ITEM_W'(front_item)),
      .full     (work_full),
      .pop      (work_pop),
      .data_out (work_data),
      .empty    (work_empty)
   );

   assign work_item = item_type'(work_data);

   mbrs_engine #(
      .MAX_WINDOW (MAX_WINDOW)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .max_run    (max_run_ff),
      .item_valid (!work_empty),
      .item       (work_item),
      .item_pop   (work_pop),
      .res_push   (res_push),
      .res        (res_item),
      .res_full   (res_full),
      .stat       (eng_stat)
   );

   mbrs_fifo #(
      .WIDTH (RES_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_result_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (res_push),
      .data_in  (RES_W'(res_item)),
      .full     (res_full),
      .pop      (pop),
      .data_out (rsp_data),
      .empty    (empty)
   );

   assign rsp_item      = result_type'(rsp_data);
   assign rsp_best_sum  = rsp_item.best_sum;
   assign rsp_final_res = rsp_item.final_res;

   `MBRS_ASSERT_NOW(a_deque_bound, 1'b1, !eng_stat.overrun, "deque count above capacity")
   `MBRS_ASSERT_NOW(a_result_room, res_push, !res_full, "result transfer into a full queue")
   `MBRS_ASSERT_NEXT(a_final_clears, res_push && res_item.final_res, eng_stat.cleared,
                     "state not cleared after closing result")

endmodule

FILE: bench/bounded_run_sum_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_run_sum_checker
// Watches the request, response and csr ports of the bounded-run selector,
// tracks the running scores and the sliding-window deque on its own, and
// compares every response transfer with the oldest predicted best sum.
// ----------------------------------------------------------------------------
module bounded_run_sum_checker
   import mbrs_pkg::*;
#(
   parameter int MAX_WINDOW = 1024
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  logic                      full,
   input  logic signed [VALUE_W-1:0] req_value,
   input  logic                      req_last,
   input  logic                      empty,
   input  logic                      pop,
   input  logic [BEST_W-1:0]         rsp_best_sum,
   input  logic                      rsp_final_res,
   input  logic                      csr_write_en,
   input  logic [RUN_W-1:0]          csr_write_data,
   output int                        mismatch_count,
   output int                        outstanding
);

   logic [RUN_W-1:0]          run_limit;
   logic signed [SCORE_W-1:0] prefix_sum;
   logic signed [SCORE_W-1:0] skip_best;
   logic signed [SCORE_W-1:0] take_best;
   logic                      take_ok;
   logic [POS_W-1:0]          pos_count;
   logic signed [SCORE_W-1:0] win_score [MAX_WINDOW];
   logic [POS_W-1:0]          win_pos [MAX_WINDOW];
   int unsigned               dq_head;
   int unsigned               dq_count;
   result_type                best_queue [$];
   result_type                want;

   function automatic logic signed [SCORE_W-1:0] add_clamp(
      input logic signed [SCORE_W-1:0] a,
      input logic signed [SCORE_W-1:0] b
   );
      logic signed [SCORE_W:0] wide;
      wide = a + b;
      if (wide[SCORE_W] != wide[SCORE_W-1]) begin
         return wide[SCORE_W] ? SCORE_MIN : SCORE_MAX;
      end
      return wide[SCORE_W-1:0];
   endfunction

   function automatic logic signed [SCORE_W-1:0] sub_clamp(
      input logic signed [SCORE_W-1:0] a,
      input logic signed [SCORE_W-1:0] b
   );
      logic signed [SCORE_W:0] wide;
      wide = a - b;
      if (wide[SCORE_W] != wide[SCORE_W-1]) begin
         return wide[SCORE_W] ? SCORE_MIN : SCORE_MAX;
      end
      return wide[SCORE_W-1:0];
   endfunction

   task automatic clear_run();
      prefix_sum  = '0;
      skip_best   = '0;
      take_best   = SCORE_MIN;
      take_ok     = 1'b0;
      pos_count   = '0;
      dq_head     = 0;
      dq_count    = 1;
      win_score[0] = '0;
      win_pos[0]   = '0;
   endtask

   // drop entries older than span positions from the front
   task automatic retire_aged(input logic [POS_W-1:0] now, input logic [POS_W-1:0] span);
      while (dq_count > 0 && (now - win_pos[dq_head]) > span) begin
         dq_head  = (dq_head + 1) % MAX_WINDOW;
         dq_count = dq_count - 1;
      end
   endtask

   task automatic advance_best_sum(input logic signed [VALUE_W-1:0] v, input logic last_in);
      logic [POS_W-1:0]          span;
      logic [POS_W-1:0]          pos;
      logic signed [SCORE_W-1:0] v_wide;
      logic signed [SCORE_W-1:0] next_skip;
      logic signed [SCORE_W-1:0] gap;
      logic signed [SCORE_W-1:0] best;
      int unsigned               back;
      int unsigned               slot;
      result_type                item;
      span   = (run_limit > MAX_WINDOW) ? MAX_WINDOW : run_limit;
      pos    = pos_count + 1;
      v_wide = v;
      prefix_sum = add_clamp(prefix_sum, v_wide);
      next_skip  = skip_best;
      if (take_ok && take_best > next_skip) begin
         next_skip = take_best;
      end
      retire_aged(pos, span);
      if (dq_count > 0) begin
         take_best = add_clamp(win_score[dq_head], prefix_sum);
         take_ok   = 1'b1;
      end else begin
         take_best = SCORE_MIN;
         take_ok   = 1'b0;
      end
      skip_best = next_skip;
      retire_aged(pos + 1, span);
      gap = sub_clamp(skip_best, prefix_sum);
      while (dq_count > 0) begin
         back = (dq_head + dq_count - 1) % MAX_WINDOW;
         if (win_score[back] > gap) break;
         dq_count = dq_count - 1;
      end
      if (dq_count < MAX_WINDOW) begin
         slot = (dq_head + dq_count) % MAX_WINDOW;
         win_score[slot] = gap;
         win_pos[slot]   = pos;
         dq_count = dq_count + 1;
      end
      pos_count = pos;
      best = skip_best;
      if (take_ok && take_best > best) begin
         best = take_best;
      end
      if (best < 0) begin
         best = '0;
      end
      item.best_sum  = best[BEST_W-1:0];
      item.final_res = last_in;
      best_queue.insert(best_queue.size(), item);
      if (last_in) begin
         clear_run();
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         run_limit = RUN_W'(1);
         clear_run();
         best_queue.delete();
         mismatch_count = 0;
      end else begin
         if (csr_write_en) begin
            run_limit = csr_write_data;
         end
         if (push && !full) begin
            advance_best_sum(req_value, req_last);
         end
         if (pop && !empty) begin
            if (best_queue.size() == 0) begin
               $error("unexpected result transfer: best_sum %0d final_res %0d",
                      rsp_best_sum, rsp_final_res);
               mismatch_count = mismatch_count + 1;
            end else begin
               want = best_queue.pop_front();
               if (rsp_best_sum !== want.best_sum) begin
                  $error("best_sum: expected %0d, actual %0d", want.best_sum, rsp_best_sum);
                  mismatch_count = mismatch_count + 1;
               end
               if (rsp_final_res !== want.final_res) begin
                  $error("final_res: expected %0d, actual %0d", want.final_res,
                         rsp_final_res);
                  mismatch_count = mismatch_count + 1;
               end
            end
         end
      end
      outstanding <= best_queue.size();
   end

endmodule

FILE: bench/max_sum_bounded_run_select_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// max_sum_bounded_run_select_top_tb
// Drives value sequences through the bounded-run selector: a directed pass
// over extreme values, a zero and an oversized run limit and a limit change
// mid-sequence, then random sequences under several run limits and idle and
// stall patterns. A side checker predicts and compares every result.
// ----------------------------------------------------------------------------
module max_sum_bounded_run_select_top_tb;
   import mbrs_pkg::*;

   localparam int MAX_WINDOW = 1024;
   localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      push = 1'b0;
   logic                      full;
   logic signed [VALUE_W-1:0] req_value = '0;
   logic                      req_last = 1'b0;
   logic                      empty;
   logic                      pop = 1'b0;
   logic [BEST_W-1:0]         rsp_best_sum;
   logic                      rsp_final_res;
   logic                      csr_write_en = 1'b0;
   logic [RUN_W-1:0]          csr_write_data = '0;
   int                        mismatch_count;
   int                        outstanding;
   int                        send_idle_pct = 0;
   int                        recv_stall_pct = 0;
   int                        seq_left = 0;

   max_sum_bounded_run_select_top #(.MAX_WINDOW(MAX_WINDOW)) dut (
      .clock          (clock),
      .reset          (reset),
      .push           (push),
      .full           (full),
      .req_value      (req_value),
      .req_last       (req_last),
      .empty          (empty),
      .pop            (pop),
      .rsp_best_sum   (rsp_best_sum),
      .rsp_final_res  (rsp_final_res),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

   bounded_run_sum_checker #(.MAX_WINDOW(MAX_WINDOW)) result_check (
      .clock          (clock),
      .reset          (reset),
      .push           (push),
      .full           (full),
      .req_value      (req_value),
      .req_last       (req_last),
      .empty          (empty),
      .pop            (pop),
      .rsp_best_sum   (rsp_best_sum),
      .rsp_final_res  (rsp_final_res),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .mismatch_count (mismatch_count),
      .outstanding    (outstanding)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      pop <= !reset && ($urandom_range(0, 99) >= recv_stall_pct);
   end

   task automatic send_item(input logic signed [VALUE_W-1:0] v, input logic l);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         push <= 1'b0;
         @(posedge clock);
      end
      push      <= 1'b1;
      req_value <= v;
      req_last  <= l;
      @(posedge clock);
      while (full) @(posedge clock);
   endtask

   // hold the sender until every predicted result has been transferred
   task automatic settle_idle();
      push <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   task automatic set_max_run(input logic [RUN_W-1:0] v);
      csr_write_en   <= 1'b1;
      csr_write_data <= v;
      @(posedge clock);
      csr_write_en   <= 1'b0;
   endtask

   function automatic logic signed [VALUE_W-1:0] pick_value();
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return $signed($urandom_range(0, 100)) - 50;
         4, 5:       return $urandom_range(0, 1000);
         6, 7:       return $urandom;
         8:          return $urandom_range(0, 1) ? VAL_MAX : VAL_MIN;
         default:    return $signed($urandom_range(0, 2)) - 1;
      endcase
   endfunction

   function automatic logic [RUN_W-1:0] pick_run();
      case ($urandom_range(0, 7))
         0:       return RUN_W'(0);
         1:       return RUN_W'(1);
         2:       return RUN_W'($urandom_range(2, 4));
         3:       return RUN_W'($urandom_range(5, 32));
         4:       return RUN_W'(MAX_WINDOW);
         5:       return RUN_W'($urandom_range(MAX_WINDOW + 1, 2047));
         6:       return RUN_W'(2047);
         default: return RUN_W'($urandom_range(0, 2047));
      endcase
   endfunction

   task automatic send_random(input int count);
      for (int i = 0; i < count; i++) begin
         if (seq_left == 0) begin
            seq_left = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 20)
                                                     : $urandom_range(30, 200);
         end
         seq_left = seq_left - 1;
         send_item(pick_value(), seq_left == 0);
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // run limit one out of reset
      send_item(VAL_MAX, 1'b0);
      send_item(VAL_MIN, 1'b0);
      send_item(VAL_MAX, 1'b0);
      send_item(VAL_MAX, 1'b0);
      send_item(-1, 1'b0);
      send_item(0, 1'b1);
      send_item(VAL_MIN, 1'b1);
      send_item(VAL_MAX, 1'b1);

      // zero run limit: picking is never allowed
      settle_idle();
      set_max_run(RUN_W'(0));
      send_item(5, 1'b0);
      send_item(7, 1'b0);
      send_item(-3, 1'b0);
      send_item(VAL_MAX, 1'b1);

      // limit above window capacity
      settle_idle();
      set_max_run(RUN_W'(2047));
      send_item(VAL_MAX, 1'b0);
      send_item(VAL_MAX, 1'b0);
      send_item(VAL_MAX, 1'b0);
      send_item(VAL_MIN, 1'b0);
      send_item(VAL_MAX, 1'b0);
      send_item(1, 1'b1);

      // shrink the limit in the middle of a sequence
      settle_idle();
      set_max_run(RUN_W'(3));
      send_item(10, 1'b0);
      send_item(10, 1'b0);
      send_item(10, 1'b0);
      settle_idle();
      set_max_run(RUN_W'(1));
      send_item(10, 1'b0);
      send_item(10, 1'b1);

      for (int mode = 0; mode < 4; mode++) begin
         case (mode)
            0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1:       begin send_idle_pct = 57; recv_stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  recv_stall_pct = 57; end
            default: begin send_idle_pct = 32; recv_stall_pct = 32; end
         endcase
         for (int sub = 0; sub < 4; sub++) begin
            settle_idle();
            set_max_run(pick_run());
            send_random(78);
         end
      end

      settle_idle();
      repeat (30) @(posedge clock);
      if (mismatch_count == 0 && outstanding == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   initial begin
      #10_000_000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule
